// ===== rtl/mrld_pkg.sv =====
// Shared constants and types for the Manchester run-length decoder.
package mrld_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int RUN_W       = 16;
	localparam int UNIT_W      = LENGTH_BITS + 1;
	localparam int PROD_W      = LENGTH_BITS + 5;
	localparam int SPREAD_W    = UNIT_W + 4;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		CLS_ERR,
		CLS_ONE,
		CLS_TWO
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [UNIT_W-1:0] unit;
		logic              first;
		logic              last;
	} cls_item_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_value;
		logic frame_done;
		logic frame_ok;
	} result_t;

endpackage

// ===== rtl/mrld_front.sv =====
// Front end: tracks frame start and reference length, classifies each run.
module mrld_front import mrld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [RUN_W-1:0] run_length,
	input  logic             last_run,
	output cls_item_t        item
);

	logic [LENGTH_BITS-1:0] ref_q;
	logic                   start_q;
	logic [LENGTH_BITS-1:0] len;
	logic [LENGTH_BITS-1:0] ref_eff;
	logic [PROD_W-1:0]      ref9, ref11, ref18, ref22, len9, len11;
	logic                   is_one, is_two;

	assign len     = LENGTH_BITS'(run_length);
	assign ref_eff = start_q ? len : ref_q;

	assign ref9  = PROD_W'(ref_eff) * PROD_W'(9);
	assign ref11 = PROD_W'(ref_eff) * PROD_W'(11);
	assign ref18 = PROD_W'(ref_eff) * PROD_W'(18);
	assign ref22 = PROD_W'(ref_eff) * PROD_W'(22);
	assign len9  = PROD_W'(len) * PROD_W'(9);
	assign len11 = PROD_W'(len) * PROD_W'(11);

	assign is_one = (ref9 <= len11) && (len9 <= ref11);
	assign is_two = (ref18 <= len11) && (len9 <= ref22);

	always_comb begin
		item.first = start_q;
		item.last  = last_run;
		if (is_one) begin
			item.cls  = CLS_ONE;
			item.unit = {len, 1'b0};
		end else if (is_two) begin
			item.cls  = CLS_TWO;
			item.unit = {1'b0, len};
		end else begin
			item.cls  = CLS_ERR;
			item.unit = {1'b0, len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			ref_q   <= '0;
		end else if (accept) begin
			start_q <= last_run;
			if (start_q) begin
				ref_q <= len;
			end
		end
	end

endmodule

// ===== rtl/mrld_cq.sv =====
// Short queue of classified items between front and back end.
module mrld_cq import mrld_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t din,
	output logic      full,
	input  logic      pop,
	output cls_item_t dout,
	output logic      empty
);

	cls_item_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push, do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mrld_back.sv =====
// Back end: pairs half-bits, emits bits, keeps frame statistics, queues results.
module mrld_back import mrld_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cls_item_t item,
	input  logic      item_empty,
	output logic      item_pop,
	output result_t   res,
	output logic      res_empty,
	input  logic      res_pop
);

	logic              line_q, hp_q, pl_q, err_q, fb_q, hb_q, lb_q;
	logic [UNIT_W-1:0] max_q, min_q;

	logic              line_n, hp_n, pl_n, err_n, fb_n, hb_n, lb_n;
	logic [UNIT_W-1:0] max_n, min_n;
	logic              vb, bv, ok;
	logic              emit;
	logic [SPREAD_W-1:0] max9, min11;

	result_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               res_full, do_push, do_pop;
	result_t            res_n;

	assign res_full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign res_empty = (cnt_q == '0);
	assign item_pop  = !item_empty && !res_full;
	assign do_push   = item_pop;
	assign do_pop    = res_pop && !res_empty;
	assign res       = mem_q[rd_q];

	always_comb begin
		line_n = item.first ? 1'b1 : line_q;
		hp_n   = item.first ? 1'b0 : hp_q;
		pl_n   = item.first ? 1'b0 : pl_q;
		err_n  = item.first ? 1'b0 : err_q;
		fb_n   = item.first ? 1'b0 : fb_q;
		hb_n   = item.first ? 1'b0 : hb_q;
		lb_n   = item.first ? 1'b0 : lb_q;
		max_n  = item.first ? '0 : max_q;
		min_n  = item.first ? '1 : min_q;
		emit   = 1'b0;
		vb     = 1'b0;
		bv     = 1'b0;
		if (!err_n) begin
			if (item.cls == CLS_ERR) begin
				err_n = 1'b1;
			end else begin
				if (item.unit > max_n) begin
					max_n = item.unit;
				end
				if (item.unit < min_n) begin
					min_n = item.unit;
				end
				if (!hp_n) begin
					// two halves with nothing pending pair at the same level
					if (item.cls == CLS_TWO) begin
						err_n = 1'b1;
					end else begin
						hp_n = 1'b1;
					end
					pl_n = line_n;
				end else begin
					hp_n = 1'b0;
					if (pl_n == line_n) begin
						err_n = 1'b1;
					end else begin
						emit = 1'b1;
						if (item.cls == CLS_TWO) begin
							hp_n = 1'b1;
						end
					end
				end
				if (emit) begin
					vb = 1'b1;
					bv = pl_n;
					if (!hb_n) begin
						fb_n = pl_n;
					end
					hb_n = 1'b1;
					lb_n = pl_n;
					if (item.cls == CLS_TWO) begin
						pl_n = line_n;
					end
				end
			end
		end
		line_n = !line_n;
		max9   = SPREAD_W'(max_n) * SPREAD_W'(9);
		min11  = SPREAD_W'(min_n) * SPREAD_W'(11);
		ok     = item.last && !err_n && !hp_n && hb_n && fb_n && !lb_n && !(max9 > min11);
		res_n.bit_valid  = vb;
		res_n.bit_value  = vb && bv;
		res_n.frame_done = item.last;
		res_n.frame_ok   = ok;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= 1'b1;
			hp_q   <= 1'b0;
			pl_q   <= 1'b0;
			err_q  <= 1'b0;
			fb_q   <= 1'b0;
			hb_q   <= 1'b0;
			lb_q   <= 1'b0;
			max_q  <= '0;
			min_q  <= '1;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				line_q <= line_n;
				hp_q   <= hp_n;
				pl_q   <= pl_n;
				err_q  <= err_n;
				fb_q   <= fb_n;
				hb_q   <= hb_n;
				lb_q   <= lb_n;
				max_q  <= max_n;
				min_q  <= min_n;
				wr_q   <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/manchester_run_length_decoder.sv =====
// Top level of the Manchester run-length decoder.
// Throughput: one item per cycle while full is low. The front end classifies,
// a 2-entry queue feeds the back end, and a 2-entry result queue decouples
// the output side; a full result queue holds items back in the item queue.
// Reset (arst_n low, asynchronous) empties both queues and starts a new frame.
module manchester_run_length_decoder import mrld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [RUN_W-1:0] run_length,
	input  logic             last_run,
	output logic             empty,
	input  logic             pop,
	output logic             bit_valid,
	output logic             bit_value,
	output logic             frame_done,
	output logic             frame_ok
);

	cls_item_t front_item, back_item;
	logic      accept, cq_empty, cq_pop;
	result_t   res;

	assign accept = push && !full;

	mrld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.run_length (run_length),
		.last_run   (last_run),
		.item       (front_item)
	);

	mrld_cq u_cq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (full),
		.pop    (cq_pop),
		.dout   (back_item),
		.empty  (cq_empty)
	);

	mrld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_empty (cq_empty),
		.item_pop   (cq_pop),
		.res        (res),
		.res_empty  (empty),
		.res_pop    (pop)
	);

	assign bit_valid  = res.bit_valid;
	assign bit_value  = res.bit_value;
	assign frame_done = res.frame_done;
	assign frame_ok   = res.frame_ok;

endmodule

// ===== rtl/mrld_checker.sv =====
// Port-level checks for the Manchester run-length decoder, bound to the top level.
module mrld_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic bit_valid,
	input logic bit_value,
	input logic frame_done,
	input logic frame_ok
);

	a_reset_clear: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not clear after reset");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_ok |-> frame_done)
		else $error("frame_ok without frame_done");

	a_ok_ends_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_ok |-> bit_valid && !bit_value)
		else $error("clean frame must end on a completed 0 bit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty
			&& $stable({bit_valid, bit_value, frame_done, frame_ok}))
		else $error("waiting item changed or vanished");

endmodule

bind manchester_run_length_decoder mrld_checker u_mrld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.bit_valid  (bit_valid),
	.bit_value  (bit_value),
	.frame_done (frame_done),
	.frame_ok   (frame_ok)
);

// ===== tb/sv/manchester_run_length_decoder_checker.sv =====
// Checker for the Manchester run-length decoder: predicts each result and compares.
`timescale 1ns / 1ps

module manchester_run_length_decoder_checker import mrld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [RUN_W-1:0] run_length,
	input  logic             last_run,
	input  logic             empty,
	input  logic             pop,
	input  logic             bit_valid,
	input  logic             bit_value,
	input  logic             frame_done,
	input  logic             frame_ok,
	output int               fail_count,
	output int               waiting,
	output int               frames_clean,
	output int               frames_failed,
	output int               bits_seen
);

	logic [LENGTH_BITS-1:0] ref_len;
	logic                   at_start;
	logic                   level;
	logic                   half_pend;
	logic                   pend_level;
	logic [UNIT_W-1:0]      unit_hi;
	logic [UNIT_W-1:0]      unit_lo;
	logic                   frame_err;
	logic                   first_b;
	logic                   have_b;
	logic                   latest_b;

	result_t expected_q[$];

	initial begin
		fail_count    = 0;
		waiting       = 0;
		frames_clean  = 0;
		frames_failed = 0;
		bits_seen     = 0;
		ref_len       = '0;
		at_start      = 1'b1;
	end

	function automatic cls_t classify_run(int unsigned len, int unsigned refl);
		if (9 * refl <= 11 * len && 9 * len <= 11 * refl)
			return CLS_ONE;
		if (18 * refl <= 11 * len && 9 * len <= 22 * refl)
			return CLS_TWO;
		return CLS_ERR;
	endfunction

	function automatic result_t decode_run(logic [LENGTH_BITS-1:0] len, logic last);
		result_t           r;
		cls_t              c;
		logic [UNIT_W-1:0] u;
		int                nh;
		r = '0;
		if (at_start) begin
			ref_len    = len;
			level      = 1'b1;
			half_pend  = 1'b0;
			pend_level = 1'b0;
			unit_hi    = '0;
			unit_lo    = '1;
			frame_err  = 1'b0;
			first_b    = 1'b0;
			have_b     = 1'b0;
			latest_b   = 1'b0;
			at_start   = 1'b0;
		end
		if (!frame_err) begin
			c = classify_run(32'(len), 32'(ref_len));
			if (c == CLS_ERR) begin
				frame_err = 1'b1;
			end else begin
				nh = (c == CLS_ONE) ? 1 : 2;
				u  = (c == CLS_ONE) ? {len, 1'b0} : {1'b0, len};
				if (u > unit_hi)
					unit_hi = u;
				if (u < unit_lo)
					unit_lo = u;
				for (int h = 0; h < nh && !frame_err; h++) begin
					if (!half_pend) begin
						half_pend  = 1'b1;
						pend_level = level;
					end else begin
						half_pend = 1'b0;
						if (pend_level == level) begin
							frame_err = 1'b1;
						end else begin
							r.bit_valid = 1'b1;
							r.bit_value = pend_level;
							if (!have_b)
								first_b = pend_level;
							have_b   = 1'b1;
							latest_b = pend_level;
						end
					end
				end
			end
		end
		level = !level;
		if (last) begin
			r.frame_done = 1'b1;
			r.frame_ok   = !frame_err && !half_pend && have_b && first_b && !latest_b
				&& !(9 * int'(unit_hi) > 11 * int'(unit_lo));
			at_start     = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic exp_v, input logic act_v);
		if (act_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %b, got %b", $time, field, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (!arst_n) begin
			expected_q.delete();
			at_start = 1'b1;
			ref_len  = '0;
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t ns: result with none expected, got %b%b%b%b", $time,
						bit_valid, bit_value, frame_done, frame_ok);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					check_field("bit_valid", e.bit_valid, bit_valid);
					check_field("bit_value", e.bit_value, bit_value);
					check_field("frame_done", e.frame_done, frame_done);
					check_field("frame_ok", e.frame_ok, frame_ok);
				end
				if (frame_done === 1'b1) begin
					if (frame_ok === 1'b1)
						frames_clean++;
					else
						frames_failed++;
				end
				if (bit_valid === 1'b1)
					bits_seen++;
			end
			if (push && !full)
				expected_q = {expected_q, decode_run(run_length[LENGTH_BITS-1:0], last_run)};
		end
		waiting = expected_q.size();
	end

endmodule

// ===== tb/sv/manchester_run_length_decoder_tb.sv =====
// Testbench top for the Manchester run-length decoder: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module manchester_run_length_decoder_tb import mrld_pkg::*;;

	localparam int RUN_TARGET = 600;
	localparam int QUIET_FROM = 500;
	localparam int PAUSE_AT   = 300;
	localparam int STALL_MAX  = 1000;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	logic [RUN_W-1:0] run_length;
	logic             last_run;
	logic             empty;
	logic             pop;
	logic             bit_valid;
	logic             bit_value;
	logic             frame_done;
	logic             frame_ok;

	int fail_count;
	int waiting;
	int frames_clean;
	int frames_failed;
	int bits_seen;

	int          runs_sent;
	int          stall_left;
	int          stall_cycles;
	bit          idle_on;
	bit          send_gaps;
	bit          paused;
	int unsigned runs_q[$];
	int unsigned half_len;
	int          kind;
	int          flaw;
	int          nbits;

	manchester_run_length_decoder i_dut (.*);

	manchester_run_length_decoder_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned jitter(int unsigned base, int pct);
		int d;
		int v;
		d = int'(base) * pct / 100;
		v = int'(base) + int'($urandom_range(0, 2 * d)) - d;
		if (v < 1)
			v = 1;
		if (v > 65535)
			v = 65535;
		return unsigned'(v);
	endfunction

	// Manchester-encode a bit string starting with 1 into line runs.
	task automatic build_frame(input int nb, input int unsigned t, input int pct, input bit end_one);
		bit halves[$];
		bit b;
		int cnt;
		runs_q.delete();
		for (int i = 0; i < nb; i++) begin
			if (i == 0)
				b = 1'b1;
			else if (i == nb - 1)
				b = end_one;
			else
				b = $urandom_range(0, 1);
			halves = {halves, b};
			halves = {halves, !b};
		end
		cnt = 1;
		for (int i = 1; i <= halves.size(); i++) begin
			if (i == halves.size() || halves[i] != halves[i-1]) begin
				runs_q = {runs_q, jitter(cnt * t, pct)};
				cnt = 1;
			end else begin
				cnt++;
			end
		end
	endtask

	task automatic send_run(input int unsigned len, input bit last);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		push       <= 1'b1;
		run_length <= len[RUN_W-1:0];
		last_run   <= last;
		do @(posedge clk); while (full);
		runs_sent++;
		@(negedge clk);
	endtask

	task automatic play_frame();
		send_gaps = idle_on && ($urandom_range(0, 3) != 0);
		for (int i = 0; i < runs_q.size(); i++)
			send_run(runs_q[i], i == runs_q.size() - 1);
	endtask

	// result side: random stall bursts, none at the tail
	initial begin
		pop        = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(0, 7);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_MAX) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("watchdog: no item moved for %0d cycles", STALL_MAX);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		run_length = '0;
		last_run   = 1'b0;
		runs_sent  = 0;
		idle_on    = 1'b1;
		paused     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-run frame, always rejected
		runs_q = '{65535};
		play_frame();
		// zero reference: zero runs classify, a nonzero one does not
		runs_q = '{0, 0, 0, 5};
		play_frame();
		// clean frames at the largest and smallest half-bit
		runs_q = '{32767, 65534, 32767};
		play_frame();
		runs_q = '{1, 2, 1};
		play_frame();
		// out-of-range run
		runs_q = '{1, 65535};
		play_frame();
		// two halves of one level paired
		runs_q = '{10, 10, 20, 10};
		play_frame();
		// unpaired half-bit at the end
		runs_q = '{10, 10, 10};
		play_frame();
		// per-unit spread too wide
		runs_q = '{100, 240, 82};
		play_frame();

		while (runs_sent < RUN_TARGET) begin
			if (runs_sent >= QUIET_FROM)
				idle_on = 1'b0;
			if (!paused && runs_sent >= PAUSE_AT) begin
				paused = 1'b1;
				push <= 1'b0;
				wait (waiting == 0);
				@(negedge clk);
			end
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				runs_q.delete();
				repeat ($urandom_range(1, 6))
					runs_q = {runs_q, ($urandom_range(0, 1) ? $urandom_range(0, 65535)
						: $urandom_range(0, 40))};
			end else begin
				half_len = ($urandom_range(0, 15) == 0) ? $urandom_range(2000, 31000)
					: $urandom_range(1, 300);
				nbits = $urandom_range(2, 10);
				flaw  = $urandom_range(0, 9);
				build_frame(nbits, half_len, (flaw == 3) ? $urandom_range(15, 25)
					: $urandom_range(0, 6), flaw == 2);
				if (flaw == 0)
					runs_q[$urandom_range(0, runs_q.size() - 1)] = $urandom_range(0, 65535);
				else if (flaw == 1 && runs_q.size() > 1)
					void'(runs_q.pop_back());
			end
			play_frame();
		end
		push <= 1'b0;
		wait (waiting == 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d runs: %0d frames decoded clean, %0d rejected, %0d data bits out.",
			runs_sent, frames_clean, frames_failed, bits_seen);
		$display("Frames mixed clean, jittered, corrupted and random runs under random stalls.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== manchester_run_length_decoder.f =====
rtl/mrld_pkg.sv
rtl/mrld_front.sv
rtl/mrld_cq.sv
rtl/mrld_back.sv
rtl/manchester_run_length_decoder.sv
rtl/mrld_checker.sv
tb/sv/manchester_run_length_decoder_checker.sv
tb/sv/manchester_run_length_decoder_tb.sv
